// ----- src/rgbled_pkg.sv -----
package rgbled_pkg;

    // Mode codes, as reported on the active mode output
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_CROSSFADE = 2'd0;
    localparam t_mode MODE_RED       = 2'd1;
    localparam t_mode MODE_BLUE      = 2'd2;
    localparam t_mode MODE_GREEN     = 2'd3;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_PWM_LOAD      = 2'd0;
    localparam t_cfg_index CFG_HOLD_LIMIT    = 2'd1;
    localparam t_cfg_index CFG_DELAY_INITIAL = 2'd2;
    localparam t_cfg_index CFG_DELAY_STEP    = 2'd3;

    // Button tracker states
    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_PRESSED  = 5'b00010,
        PH_HOLD     = 5'b00100,
        PH_LONG     = 5'b01000,
        PH_RELEASED = 5'b10000
    } t_btn_phase;

    typedef struct packed {
        t_btn_phase  phase;
        logic [7:0]  count;
    } t_btn_track;

    // Crossfade phases, named after the rising channel
    typedef enum logic [2:0] {
        FADE_RED   = 3'b001,
        FADE_GREEN = 3'b010,
        FADE_BLUE  = 3'b100
    } t_fade_phase;

    // Reset values
    localparam logic [15:0] PWM_LOAD_RESET      = 16'd11362;
    localparam logic [7:0]  HOLD_LIMIT_RESET    = 8'd100;
    localparam logic [23:0] DELAY_INITIAL_RESET = 24'd100000;
    localparam logic [23:0] DELAY_STEP_RESET    = 24'd10000;
    localparam logic [7:0]  RED_LEVEL_RESET     = 8'd254;
    localparam logic [7:0]  GREEN_LEVEL_RESET   = 8'd1;
    localparam logic [7:0]  BLUE_LEVEL_RESET    = 8'd1;

    localparam logic [7:0]  LEVEL_MAX = 8'd255;
    localparam logic [7:0]  LEVEL_MIN = 8'd1;
    localparam logic [7:0]  LEVEL_TURN = 8'd2;
    localparam logic [7:0]  COUNT_MAX = 8'd255;
    localparam logic [23:0] DELAY_MAX = 24'hFFFFFF;

    // Divide by 1000: drop three bits, then multiply by a reciprocal of 125.
    // The rounding error of the reciprocal stays below one for 21-bit values.
    localparam int PROD_W     = 24;
    localparam int PRE_SHIFT  = 3;
    localparam int DIV_SHIFT  = 28;
    localparam int DIV_MUL_W  = 22;
    localparam int QUO_W      = 15;
    localparam int DIV_FULL_W = PROD_W - PRE_SHIFT + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((64'd1 << DIV_SHIFT) + 64'd124) / 64'd125);

endpackage

// ----- src/rgb_led_button_mode_controller.sv -----
// RGB LED button mode controller.
// Input channel: one transfer per tick, carrying the two button levels
// (1 = pressed). Output channel: one result per tick with the three PWM
// pulse widths (level * load / 1000), the tick delay and the active mode.
// Configuration: a plain write port; registers are load (0), hold limit (1),
// initial delay (2) and delay step (3). The user must write them only while
// the block is idle; the block itself does not enforce this. Throughput: one
// tick per cycle while the receiver takes results. The tick's state update
// and a level snapshot are registered at the input transfer; the widths then
// go through a product stage (level times load) and a reciprocal-divide stage.
// Stalls: each stage holds its item until the next one is free; when the
// receiver holds off, the pipeline fills and input ready drops only once
// all three stages are occupied.
// Reset (synchronous, active low): registers take their default values,
// both buttons go idle, auto mode, green phase, levels 254/1/1, delay
// loaded with the initial delay, pipeline emptied.
module rgb_led_button_mode_controller
    import rgbled_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_button_one_down,
    input  logic        i_button_two_down,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_red_width,
    output logic [15:0] o_blue_width,
    output logic [15:0] o_green_width,
    output logic [23:0] o_tick_delay,
    output logic [1:0]  o_active_mode
);

    function automatic logic [7:0] level_up(input logic [7:0] v);
        return (v != LEVEL_MAX) ? v + 8'd1 : v;
    endfunction

    function automatic logic [7:0] level_down(input logic [7:0] v);
        return (v > LEVEL_MIN) ? v - 8'd1 : v;
    endfunction

    function automatic t_btn_track track_button(input logic down, input t_btn_track cur,
                                                input logic [7:0] limit);
        t_btn_track nxt;
        nxt = cur;
        if (down) begin
            unique case (cur.phase)
                PH_IDLE:    nxt.phase = PH_PRESSED;
                PH_PRESSED: nxt.phase = PH_HOLD;
                PH_HOLD: begin
                    if (cur.count != COUNT_MAX) nxt.count = cur.count + 8'd1;
                end
                default: ;
            endcase
            if (cur.phase != PH_LONG && nxt.count > limit) nxt.phase = PH_LONG;
        end else begin
            unique case (cur.phase)
                PH_PRESSED, PH_HOLD, PH_LONG: nxt.phase = PH_RELEASED;
                PH_RELEASED:                  nxt.phase = PH_IDLE;
                default: ;
            endcase
            nxt.count = 8'd0;
        end
        return nxt;
    endfunction

    // Configuration registers
    logic [15:0] r_pwm_load;
    logic [7:0]  r_hold_limit;
    logic [23:0] r_delay_initial;
    logic [23:0] r_delay_step;

    // Tick state
    t_btn_track  r_btn_one, n_btn_one;
    t_btn_track  r_btn_two, n_btn_two;
    t_mode       r_mode, n_mode;
    t_mode       r_pending, n_pending;
    t_fade_phase r_fade, n_fade;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_blue, n_blue;
    logic [23:0] r_delay, n_delay;

    // Pipeline stages
    logic        r_v1, r_v2, r_v3;
    logic [7:0]  r1_red, r1_green, r1_blue;
    logic [23:0] r1_delay, r2_delay, r3_delay;
    t_mode       r1_mode, r2_mode, r3_mode;
    logic [PROD_W-1:0] r2_red_prod, r2_green_prod, r2_blue_prod;
    logic [15:0] r3_red, r3_green, r3_blue;

    logic accept, ld2, ld3;
    logic [24:0] w_delay_sum;
    logic [DIV_FULL_W-1:0] w_red_q, w_green_q, w_blue_q;

    // Handshake: each stage loads when it is empty or its item moves on
    assign ld3        = r_v2 & (~r_v3 | i_out_ready);
    assign ld2        = r_v1 & (~r_v2 | ld3);
    assign o_in_ready = ~r_v1 | ld2;
    assign accept     = i_in_valid & o_in_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_load      <= PWM_LOAD_RESET;
            r_hold_limit    <= HOLD_LIMIT_RESET;
            r_delay_initial <= DELAY_INITIAL_RESET;
            r_delay_step    <= DELAY_STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PWM_LOAD:      r_pwm_load      <= i_cfg_data[15:0];
                CFG_HOLD_LIMIT:    r_hold_limit    <= i_cfg_data[7:0];
                CFG_DELAY_INITIAL: r_delay_initial <= i_cfg_data;
                CFG_DELAY_STEP:    r_delay_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_delay_sum = {1'b0, r_delay} + {1'b0, r_delay_step};

    // Tick update: crossfade, button trackers, then mode and nudge actions
    always_comb begin
        n_fade    = r_fade;
        n_red     = r_red;
        n_green   = r_green;
        n_blue    = r_blue;
        n_mode    = r_mode;
        n_pending = r_pending;
        n_delay   = r_delay;

        if (r_mode == MODE_CROSSFADE) begin
            unique case (r_fade)
                FADE_GREEN: begin
                    if (r_red == LEVEL_TURN) n_fade = FADE_BLUE;
                    n_red   = level_down(r_red);
                    n_green = level_up(r_green);
                end
                FADE_BLUE: begin
                    if (r_green == LEVEL_TURN) n_fade = FADE_RED;
                    n_green = level_down(r_green);
                    n_blue  = level_up(r_blue);
                end
                FADE_RED: begin
                    if (r_blue == LEVEL_TURN) n_fade = FADE_GREEN;
                    n_blue = level_down(r_blue);
                    n_red  = level_up(r_red);
                end
                default: ;
            endcase
        end

        n_btn_one = track_button(i_button_one_down, r_btn_one, r_hold_limit);
        n_btn_two = track_button(i_button_two_down, r_btn_two, r_hold_limit);

        if (n_btn_one.phase == PH_RELEASED &&
            (n_btn_two.phase == PH_HOLD || n_btn_two.phase == PH_LONG)) begin
            if (r_pending != MODE_GREEN) n_pending = r_pending + 2'd1;
        end else if (n_btn_one.phase == PH_LONG && n_btn_two.phase == PH_LONG) begin
            n_pending = MODE_GREEN;
        end else if (n_btn_one.phase == PH_IDLE && n_btn_two.phase == PH_IDLE) begin
            // commit the pending mode
            if (r_pending != MODE_CROSSFADE) begin
                n_mode    = r_pending;
                n_delay   = r_delay_initial;
                n_pending = MODE_CROSSFADE;
            end
        end else if ((n_btn_one.phase == PH_PRESSED || n_btn_one.phase == PH_HOLD) &&
                     n_btn_two.phase == PH_IDLE) begin
            // shorten the delay, or raise the manual channel
            if (r_mode == MODE_CROSSFADE) begin
                if (r_delay > r_delay_step && n_btn_one.phase == PH_PRESSED)
                    n_delay = r_delay - r_delay_step;
            end else if (r_mode == MODE_RED) begin
                n_red = level_up(n_red);
            end else if (r_mode == MODE_BLUE) begin
                n_blue = level_up(n_blue);
            end else begin
                n_green = level_up(n_green);
            end
        end else if ((n_btn_two.phase == PH_PRESSED || n_btn_two.phase == PH_HOLD) &&
                     n_btn_one.phase == PH_IDLE) begin
            // lengthen the delay, or lower the manual channel
            if (r_mode == MODE_CROSSFADE) begin
                if (n_btn_two.phase == PH_PRESSED)
                    n_delay = w_delay_sum[24] ? DELAY_MAX : w_delay_sum[23:0];
            end else if (r_mode == MODE_RED) begin
                n_red = level_down(n_red);
            end else if (r_mode == MODE_BLUE) begin
                n_blue = level_down(n_blue);
            end else begin
                n_green = level_down(n_green);
            end
        end
    end

    // Advance tick state on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_btn_one <= '{phase: PH_IDLE, count: 8'd0};
            r_btn_two <= '{phase: PH_IDLE, count: 8'd0};
            r_mode    <= MODE_CROSSFADE;
            r_pending <= MODE_CROSSFADE;
            r_fade    <= FADE_GREEN;
            r_red     <= RED_LEVEL_RESET;
            r_green   <= GREEN_LEVEL_RESET;
            r_blue    <= BLUE_LEVEL_RESET;
            r_delay   <= DELAY_INITIAL_RESET;
        end else if (accept) begin
            r_btn_one <= n_btn_one;
            r_btn_two <= n_btn_two;
            r_mode    <= n_mode;
            r_pending <= n_pending;
            r_fade    <= n_fade;
            r_red     <= n_red;
            r_green   <= n_green;
            r_blue    <= n_blue;
            r_delay   <= n_delay;
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (accept)   r_v1 <= 1'b1;
            else if (ld2) r_v1 <= 1'b0;
            if (ld2)      r_v2 <= 1'b1;
            else if (ld3) r_v2 <= 1'b0;
            if (ld3)                    r_v3 <= 1'b1;
            else if (r_v3 & i_out_ready) r_v3 <= 1'b0;
        end
    end

    // Stage one: snapshot of the updated levels
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_red   <= n_red;
            r1_green <= n_green;
            r1_blue  <= n_blue;
            r1_delay <= n_delay;
            r1_mode  <= n_mode;
        end
    end

    // Stage two: level times load
    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_red_prod   <= r1_red * r_pwm_load;
            r2_green_prod <= r1_green * r_pwm_load;
            r2_blue_prod  <= r1_blue * r_pwm_load;
            r2_delay      <= r1_delay;
            r2_mode       <= r1_mode;
        end
    end

    // Stage three: divide by 1000 through the reciprocal
    assign w_red_q   = r2_red_prod[PROD_W-1:PRE_SHIFT] * DIV_MUL;
    assign w_green_q = r2_green_prod[PROD_W-1:PRE_SHIFT] * DIV_MUL;
    assign w_blue_q  = r2_blue_prod[PROD_W-1:PRE_SHIFT] * DIV_MUL;

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r3_red   <= {1'b0, w_red_q[DIV_SHIFT +: QUO_W]};
            r3_green <= {1'b0, w_green_q[DIV_SHIFT +: QUO_W]};
            r3_blue  <= {1'b0, w_blue_q[DIV_SHIFT +: QUO_W]};
            r3_delay <= r2_delay;
            r3_mode  <= r2_mode;
        end
    end

    assign o_out_valid   = r_v3;
    assign o_red_width   = r3_red;
    assign o_blue_width  = r3_blue;
    assign o_green_width = r3_green;
    assign o_tick_delay  = r3_delay;
    assign o_active_mode = r3_mode;

endmodule
